// ===== rtl/ncp_pkg.sv =====
// Shared types and constants for the normalized cumulative probability block.
// Used by ncp_front, ncp_queue, ncp_back and the top level; depends on nothing.
`default_nettype none

package ncp_pkg;

  localparam int FLOW_W    = 32;  // Q16.16 flows
  localparam int PROB_W    = 32;  // Q8.24 probabilities
  localparam int QUOT_BITS = 31;  // quotient bits kept below the saturation point
  localparam int PRE_SHIFT = 7;   // 31 - 24: numerator bits that sit above the quotient

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic signed [PROB_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [PROB_W-1:0] Q_MIN = 32'sh8000_0000;

  // One classified neighbor entry, waiting for the divider.
  typedef struct packed {
    logic [3:0]        slot;        // low bits of the slot counter before this entry
    logic              self_entry;  // neighbor is the compartment itself
    logic              last;        // final entry of the row
    logic              neg;         // quotient is negative
    logic [FLOW_W-1:0] num_mag;     // |neighbor_flow|
    logic [FLOW_W-1:0] div_mag;     // |diagonal_flow|
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/ncp_front.sv =====
// Front end: accepts input beats, tracks the slot counter and classifies each entry.
// Depends on ncp_pkg.
`default_nettype none

module ncp_front #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int INDEX_WIDTH   = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [95:0]  s_tdata,
  input  wire logic         s_tlast,
  input  wire logic         q_full,
  output logic              push,
  output ncp_pkg::job_t     job
);

  localparam int SLOT_CW = (MAX_NEIGHBORS > 2) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CMP_W   = (INDEX_WIDTH < 16) ? INDEX_WIDTH : 16;

  logic [SLOT_CW-1:0] slot_cnt;
  logic [SLOT_CW-1:0] slot_cnt_next;
  logic [SLOT_CW+3:0] slot_ext;
  logic [15:0]        row_idx;
  logic [15:0]        nb_idx;
  logic [31:0]        diag;
  logic [31:0]        nflow;

  assign row_idx = s_tdata[15:0];
  assign nb_idx  = s_tdata[31:16];
  assign diag    = s_tdata[63:32];
  assign nflow   = s_tdata[95:64];

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;
  assign slot_ext = {4'b0, slot_cnt};

  always_comb begin
    job.slot       = slot_ext[3:0];
    job.self_entry = (row_idx[CMP_W-1:0] == nb_idx[CMP_W-1:0]);
    job.last       = s_tlast;
    job.neg        = nflow[31];
    job.num_mag    = nflow[31] ? (~nflow + 32'd1) : nflow;
    job.div_mag    = diag[31] ? (~diag + 32'd1) : diag;
  end

  always_comb begin
    if (s_tlast) begin
      slot_cnt_next = '0;
    end else if (slot_cnt == SLOT_CW'(MAX_NEIGHBORS - 1)) begin
      slot_cnt_next = '0;
    end else begin
      slot_cnt_next = slot_cnt + SLOT_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_cnt <= '0;
    end else if (push) begin
      slot_cnt <= slot_cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ncp_queue.sv =====
// Two-entry queue of classified entries between the front end and the divider.
// Depends on ncp_pkg.
`default_nettype none

module ncp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  ncp_pkg::job_t      push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               avail,
  output ncp_pkg::job_t      pop_job
);

  ncp_pkg::job_t                  entries [ncp_pkg::QUEUE_DEPTH];
  logic [ncp_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ncp_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ncp_pkg::QCNT_W-1:0]     count;

  assign full    = (count == ncp_pkg::QCNT_W'(ncp_pkg::QUEUE_DEPTH));
  assign avail   = (count != '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + ncp_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + ncp_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + ncp_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - ncp_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ncp_back.sv =====
// Back end: restoring divider, saturating accumulation of the running sum and
// the output register. Depends on ncp_pkg.
`default_nettype none

module ncp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_avail,
  input  ncp_pkg::job_t      q_job,
  output logic               q_pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [39:0]        m_tdata,
  output logic [0:0]         m_tuser,
  output logic               m_tlast
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int W  = ncp_pkg::FLOW_W;
  localparam int QB = ncp_pkg::QUOT_BITS;
  localparam int PS = ncp_pkg::PRE_SHIFT;

  logic [1:0]          state;
  logic [4:0]          cnt;
  logic [3:0]          job_slot;
  logic                job_self;
  logic                job_last;
  logic                job_neg;
  logic                job_zero;
  logic                job_sat;
  logic [W-1:0]        div_m;
  logic [W-1:0]        rem;
  logic [QB-1:0]       num_sh;
  logic [QB-1:0]       qmag;
  logic signed [31:0]  rsum;

  logic                out_valid;
  logic [3:0]          out_slot;
  logic [31:0]         out_cum;
  logic                out_written;
  logic                out_last;

  logic                out_free;
  logic                done_go;
  logic [W:0]          trial;
  logic [W:0]          trial_diff;
  logic                trial_ge;
  logic                ovf_in;
  logic signed [31:0]  q_signed;
  logic signed [32:0]  sum_wide;
  logic signed [31:0]  sum_sat;

  assign out_free = !out_valid || m_tready;
  assign done_go  = (state == S_DONE) && out_free;
  assign q_pop    = (state == S_IDLE) && q_avail;

  // Quotient of at least 2^31 shows up as |nf| >= |diag| * 2^7.
  assign ovf_in = ({{PS{1'b0}}, q_job.num_mag} >= {q_job.div_mag, {PS{1'b0}}});

  assign trial      = {rem, num_sh[QB-1]};
  assign trial_diff = trial - {1'b0, div_m};
  assign trial_ge   = (trial >= {1'b0, div_m});

  always_comb begin
    if (job_zero) begin
      q_signed = '0;
    end else if (job_sat) begin
      q_signed = job_neg ? ncp_pkg::Q_MIN : ncp_pkg::Q_MAX;
    end else if (job_neg) begin
      q_signed = -$signed({1'b0, qmag});
    end else begin
      q_signed = $signed({1'b0, qmag});
    end
    sum_wide = {rsum[31], rsum} + {q_signed[31], q_signed};
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? ncp_pkg::Q_MIN : ncp_pkg::Q_MAX;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsum  <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_avail) begin
            if (q_job.self_entry || q_job.div_mag == '0 || ovf_in) begin
              state <= S_DONE;
            end else begin
              state <= S_DIV;
              cnt   <= 5'(QB - 1);
            end
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
            if (job_last) begin
              rsum <= '0;
            end else if (!job_self) begin
              rsum <= sum_sat;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_slot <= q_job.slot;
      job_self <= q_job.self_entry;
      job_last <= q_job.last;
      job_neg  <= q_job.neg;
      job_zero <= (q_job.div_mag == '0);
      job_sat  <= ovf_in;
      div_m    <= q_job.div_mag;
      rem      <= {{PS{1'b0}}, q_job.num_mag[W-1:PS]};
      num_sh   <= {q_job.num_mag[PS-1:0], {(QB - PS){1'b0}}};
      qmag     <= '0;
    end else if (state == S_DIV) begin
      rem    <= trial_ge ? trial_diff[W-1:0] : trial[W-1:0];
      num_sh <= {num_sh[QB-2:0], 1'b0};
      qmag   <= {qmag[QB-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_go) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_slot    <= job_slot;
      out_cum     <= job_self ? 32'd0 : sum_sat;
      out_written <= !job_self;
      out_last    <= job_last;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = {4'b0, out_cum, out_slot};
  assign m_tuser[0] = out_written;
  assign m_tlast    = out_last;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < div_m))
    else $error("divider remainder not below divisor");

  a_step_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt <= 5'(QB - 1)))
    else $error("divider step count out of range");

  a_self_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_written) |-> (out_cum == 32'd0))
    else $error("self entry result carries a nonzero probability");

  a_row_clears_sum: assert property (@(posedge clk) disable iff (rst)
    (done_go && job_last) |=> (rsum == 32'sd0))
    else $error("running sum not cleared after the last entry of a row");
`endif

endmodule

`default_nettype wire

// ===== rtl/normalized_cumulative_probability.sv =====
// Top level of the normalized cumulative probability block.
// Depends on ncp_pkg, ncp_front, ncp_queue and ncp_back.
//
//   Channel  Direction  Beat carries
//   s_*      in         one neighbor entry: indices, diagonal and neighbor flow, last flag
//   m_*      out        one result: slot, cumulative probability, written flag, row end
//
// An entry whose neighbor differs from the row and whose diagonal is nonzero passes
// the back end as a load, 31 restoring-division steps of the shared divider (one
// quotient bit each) and an accumulation into the output register. Self entries,
// zero diagonals and saturating quotients skip the divider: load, then accumulate.
// The divider sets the sustained rate; no entry loads until the last is accumulated.
// Reset (rst, synchronous) clears the running sum, the slot counter and the queue.
// The front end accepts a beat whenever the two-entry queue has room, so it keeps
// taking entries while the divider works; a held result in the output register
// stalls only the back end.
`default_nettype none

module normalized_cumulative_probability #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int INDEX_WIDTH   = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Input stream.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // s_tdata fields from bit 0: row_index[15:0], neighbor_index[31:16],
  // diagonal_flow[63:32], neighbor_flow[95:64].
  input  wire logic [95:0]  s_tdata,
  input  wire logic         s_tlast,   // last_in_row
  // Result stream.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // m_tdata fields from bit 0: slot[3:0], cumulative_probability[35:4], zeros above.
  output logic [39:0]       m_tdata,
  // m_tuser fields from bit 0: written[0].
  output logic [0:0]        m_tuser,
  output logic              m_tlast    // row_done
);

  logic          push;
  logic          q_full;
  logic          q_avail;
  logic          q_pop;
  ncp_pkg::job_t front_job;
  ncp_pkg::job_t queue_job;

  // The front end classifies each entry as it arrives and stamps its slot.
  ncp_front #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .INDEX_WIDTH   (INDEX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .job      (front_job)
  );

  // The queue decouples arrival from the multi-cycle division.
  ncp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_job  (queue_job)
  );

  // The back end divides, accumulates with saturation and holds the result.
  ncp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_avail  (q_avail),
    .q_job    (queue_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== bench/tb_normalized_cumulative_probability.sv =====
// Self-checking testbench for normalized_cumulative_probability.
// It drives neighbor entries, predicts each result from a local model of the prefix sum,
// and checks the results in order. Depends on ncp_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_normalized_cumulative_probability;

  // One neighbor entry as it travels on the input stream.
  typedef struct {
    logic [15:0]        row_idx;
    logic [15:0]        nb_idx;
    logic signed [31:0] diag;
    logic signed [31:0] nflow;
    logic               last;
  } entry_t;

  // One result beat as it leaves the output stream.
  typedef struct {
    logic [3:0]         slot;
    logic signed [31:0] cum;
    logic               written;
    logic               row_done;
  } result_t;

  // A row of the directed table. A typed expectation is used only where it is obvious.
  typedef struct {
    entry_t  e;
    bit      has_exp;
    result_t exp;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  normalized_cumulative_probability uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // The predictor keeps its own copy of the row state.
  logic signed [31:0] prob_sum;
  logic [3:0]         slot_count;

  result_t    expected_results[$];
  table_row_t directed_rows[$];

  int  mismatch_count = 0;
  int  items_sent     = 0;
  int  beats_seen     = 0;
  // In the closing part of the run neither side idles.
  bit  calm           = 1'b0;
  // Rows sent back to back with no source idling at all.
  bit  burst_mode     = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous timeout: several times the slowest correct run (divider plus both idle bursts).
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic signed [31:0] clamp_q824(input longint v);
    if (v > longint'(ncp_pkg::Q_MAX)) return ncp_pkg::Q_MAX;
    if (v < longint'(ncp_pkg::Q_MIN)) return ncp_pkg::Q_MIN;
    return v[31:0];
  endfunction

  // Works out the result of one accepted entry and advances the row state.
  // The quotient is neighbor_flow * 2^24 / |diagonal_flow|, truncated toward zero;
  // the Q16.16 scales cancel and leave a Q8.24 probability.
  function automatic result_t predict_cumulative(input entry_t e);
    result_t r;
    longint  mag;
    logic signed [31:0] quot;
    r.slot     = slot_count;
    r.cum      = '0;
    r.written  = 1'b0;
    r.row_done = e.last;
    if (e.row_idx != e.nb_idx) begin
      // The magnitude of the most negative diagonal is 2^31, which a longint holds.
      mag = (e.diag < 0) ? -longint'(e.diag) : longint'(e.diag);
      if (mag == 0) quot = '0;
      else quot = clamp_q824((longint'(e.nflow) * 64'sd16777216) / mag);
      r.cum     = clamp_q824(longint'(prob_sum) + longint'(quot));
      prob_sum  = r.cum;
      r.written = 1'b1;
    end
    // Sixteen slots, so the 4-bit counter wraps by itself.
    slot_count = slot_count + 4'd1;
    if (e.last) begin
      prob_sum   = '0;
      slot_count = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40)
      $display("beat %0d: %s got %h, expected %h", beats_seen, field, got, want);
    mismatch_count++;
  endtask

  // Offers one entry and waits until the block takes it. The valid line is only
  // lowered when an idle gap comes first, so it never toggles within one time step.
  task automatic send_entry(input entry_t e, input bit has_exp, input result_t typed);
    int      gap;
    result_t pred;
    gap = 0;
    if (!calm && !burst_mode && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {e.nflow, e.diag, e.nb_idx, e.row_idx};
    s_tlast  <= e.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = predict_cumulative(e);
    expected_results.push_back(has_exp ? typed : pred);
    items_sent++;
  endtask

  task automatic add_row(input logic [15:0] row_idx, input logic [15:0] nb_idx,
                         input logic [31:0] diag, input logic [31:0] nflow,
                         input logic last, input bit has_exp, input logic [3:0] slot,
                         input logic [31:0] cum, input logic written,
                         input logic row_done);
    table_row_t t;
    t.e.row_idx    = row_idx;
    t.e.nb_idx     = nb_idx;
    t.e.diag       = diag;
    t.e.nflow      = nflow;
    t.e.last       = last;
    t.has_exp      = has_exp;
    t.exp.slot     = slot;
    t.exp.cum      = cum;
    t.exp.written  = written;
    t.exp.row_done = row_done;
    directed_rows.push_back(t);
  endtask

  // Picks a diagonal flow: mostly moderate values, plus zero, the extremes and full range.
  function automatic logic signed [31:0] pick_diag();
    int          sel;
    logic [31:0] mag;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 32'sh0000_0000;
    if (sel < 8) return 32'sh8000_0000;
    if (sel < 11) return 32'sh7FFF_FFFF;
    if (sel < 14) return ($urandom_range(0, 1) != 0) ? 32'sh0000_0001 : 32'shFFFF_FFFF;
    if (sel < 34) return $urandom;
    mag = $urandom_range(32'h0000_4000, 32'h0100_0000);
    return ($urandom_range(0, 1) != 0) ? -$signed(mag) : $signed(mag);
  endfunction

  // Sink side: random stalls in bursts, long ready stretches between them.
  initial begin
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 60)) @(posedge clk);
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // Result checker. Values are sampled at the edge where the beat is taken,
  // before any assignment made at that edge lands.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata[35:4], 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[3:0] !== want.slot)
          report_mismatch("slot", {28'h0, m_tdata[3:0]}, {28'h0, want.slot});
        if (m_tdata[35:4] !== want.cum)
          report_mismatch("cumulative_probability", m_tdata[35:4], want.cum);
        if (m_tuser[0] !== want.written)
          report_mismatch("written", {31'h0, m_tuser[0]}, {31'h0, want.written});
        if (m_tlast !== want.row_done)
          report_mismatch("row_done", {31'h0, m_tlast}, {31'h0, want.row_done});
      end
      beats_seen++;
    end
  end

  initial begin
    entry_t  e;
    result_t none;
    int      row_len;
    logic [15:0] row_base;
    logic signed [31:0] row_diag;
    logic [31:0] fmag;
    int      sel;

    none = '{slot: '0, cum: '0, written: 1'b0, row_done: 1'b0};
    prob_sum   = '0;
    slot_count = '0;

    // Directed table. Columns: row, neighbor, diagonal, neighbor flow, last,
    // then a typed result (slot, probability, written, row end) where one is given.
    // A self entry straight after reset shows slot 0 and writes nothing.
    add_row(16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 0, 1, 0, 32'h0000_0000, 0, 0);
    // 0.5 / 1.0 gives 0.5 in Q8.24.
    add_row(16'h0000, 16'h0001, 32'h0001_0000, 32'h0000_8000, 0, 1, 1, 32'h0080_0000, 1, 0);
    // A zero diagonal adds nothing.
    add_row(16'h0000, 16'h0002, 32'h0000_0000, 32'h7FFF_FFFF, 0, 1, 2, 32'h0080_0000, 1, 0);
    // Largest flow over the smallest diagonal saturates quotient and sum.
    add_row(16'h0000, 16'h0003, 32'h0000_0001, 32'h7FFF_FFFF, 0, 1, 3, 32'h7FFF_FFFF, 1, 0);
    // The most negative diagonal has magnitude 2^31: -2^31 / 2^31 is -1.0.
    add_row(16'h0000, 16'h0004, 32'h8000_0000, 32'h8000_0000, 0, 1, 4, 32'h7EFF_FFFF, 1, 0);
    add_row(16'h0000, 16'h0005, 32'h0000_0001, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
    add_row(16'h0000, 16'h0006, 32'h0000_0001, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
    // The sum sits at its negative limit; a negative diagonal of -1 keeps it there.
    add_row(16'h0000, 16'h0007, 32'hFFFF_FFFF, 32'h8000_0000, 0, 1, 7, 32'h8000_0000, 1, 0);
    // A self entry that ends the row: shows the skipped slot and clears the state.
    add_row(16'h1234, 16'h1234, 32'h0001_0000, 32'h0001_0000, 1, 1, 8, 32'h0000_0000, 0, 1);
    // Fresh row at the top indices: 1.0 over |-1.0| is 1.0.
    add_row(16'hFFFF, 16'hFFFE, 32'hFFFF_0000, 32'h0001_0000, 0, 1, 0, 32'h0100_0000, 1, 0);
    add_row(16'hFFFF, 16'h0000, 32'hFFFF_0000, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0);
    add_row(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
    // Division by 3 truncates toward zero on both signs.
    add_row(16'hFFFF, 16'h7FFF, 32'h0003_0000, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
    add_row(16'hFFFF, 16'h8001, 32'h0003_0000, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0);
    add_row(16'hFFFF, 16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0, 0, 0, 0);
    // Rows of a single entry, self and not.
    add_row(16'h0000, 16'h0000, 32'h0001_0000, 32'h0001_0000, 1, 1, 0, 32'h0000_0000, 0, 1);
    add_row(16'h0000, 16'h0001, 32'h0000_0000, 32'h0000_0000, 1, 1, 0, 32'h0000_0000, 1, 1);
    // Tiny quotients and a half diagonal that saturates.
    add_row(16'h5555, 16'hAAAA, 32'h7FFF_FFFF, 32'h0000_0000, 0, 0, 0, 0, 0, 0);
    add_row(16'h5555, 16'h0006, 32'h7FFF_FFFF, 32'h0000_0001, 0, 0, 0, 0, 0, 0);
    add_row(16'h5555, 16'h0007, 32'h0000_8000, 32'h7FFF_FFFF, 1, 0, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_entry(directed_rows[i].e, directed_rows[i].has_exp, directed_rows[i].exp);

    // Random rows: each row shares one diagonal in most entries, as in a real flow map.
    // Some rows run past sixteen entries so the slot counter wraps.
    while (items_sent < 1750) begin
      calm       = (items_sent >= 1500);
      burst_mode = ($urandom_range(0, 9) < 3);
      row_base   = 16'($urandom);
      row_diag   = pick_diag();
      row_len    = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16)
                                                  : $urandom_range(17, 24);
      for (int k = 0; k < row_len; k++) begin
        e.row_idx = row_base;
        e.nb_idx  = ($urandom_range(0, 99) < 15) ? row_base : 16'($urandom);
        e.diag    = ($urandom_range(0, 9) == 0) ? pick_diag() : row_diag;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
          e.nflow = $urandom;
        end else if (sel < 30) begin
          e.nflow = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end else begin
          fmag    = $urandom_range(0, 32'h0020_0000);
          e.nflow = ($urandom_range(0, 1) != 0) ? -$signed(fmag) : $signed(fmag);
        end
        e.last = (k == row_len - 1);
        send_entry(e, 1'b0, none);
      end
    end

    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // Let any stray beat show up before the verdict.
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
